// File: rtl/plm_pkg.sv
// Shared constants, types and lane mapping for the LED matrix PWM bit-plane generator.
package plm_pkg;

    // Geometry of the panel scan
    localparam int PWM_STEPS  = 64;
    localparam int COLUMNS    = 32;
    localparam int ROW_GROUPS = 8;

    // Field widths
    localparam int DUTY_W    = 8;
    localparam int STEP_W    = 6;
    localparam int COL_W     = 5;
    localparam int ROW_W     = 3;
    localparam int WORD_W    = 14;
    localparam int POS_W     = 4;
    localparam int NUM_LANES = 12;

    // Control bit positions within a plane word
    localparam int OE_POS  = 6;
    localparam int LAT_POS = 7;

    // Last values of the counters
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PWM_STEPS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROW_GROUPS - 1);

    // Reset value of the dim threshold
    localparam logic [COL_W-1:0] DIM_RESET = 5'd31;

    // Plane word bit driven by each lane: r1 g1 b1 r2 g2 b2, then r3 g3 b3 r4 g4 b4
    localparam logic [POS_W-1:0] LANE_POS [NUM_LANES] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13
    };

    typedef logic [DUTY_W-1:0] duty_t;
    typedef logic [NUM_LANES-1:0] lane_bits_t;

    // Per-column control bits carried with an item
    typedef struct packed {
        logic oe;
        logic lat;
    } ctl_t;

endpackage

// File: rtl/plm_in_if.sv
// Input channel: twelve duty values for one column, valid/ready handshake.
interface plm_in_if;
    logic                  valid;
    logic                  ready;
    logic [plm_pkg::DUTY_W-1:0] red_p1;
    logic [plm_pkg::DUTY_W-1:0] green_p1;
    logic [plm_pkg::DUTY_W-1:0] blue_p1;
    logic [plm_pkg::DUTY_W-1:0] red_p2;
    logic [plm_pkg::DUTY_W-1:0] green_p2;
    logic [plm_pkg::DUTY_W-1:0] blue_p2;
    logic [plm_pkg::DUTY_W-1:0] red_p3;
    logic [plm_pkg::DUTY_W-1:0] green_p3;
    logic [plm_pkg::DUTY_W-1:0] blue_p3;
    logic [plm_pkg::DUTY_W-1:0] red_p4;
    logic [plm_pkg::DUTY_W-1:0] green_p4;
    logic [plm_pkg::DUTY_W-1:0] blue_p4;

    modport source (
        output valid, red_p1, green_p1, blue_p1, red_p2, green_p2, blue_p2,
               red_p3, green_p3, blue_p3, red_p4, green_p4, blue_p4,
        input  ready
    );

    modport sink (
        input  valid, red_p1, green_p1, blue_p1, red_p2, green_p2, blue_p2,
               red_p3, green_p3, blue_p3, red_p4, green_p4, blue_p4,
        output ready
    );
endinterface

// File: rtl/plm_out_if.sv
// Output channel: one plane word per PWM step, valid/ready handshake.
interface plm_out_if;
    logic                       valid;
    logic                       ready;
    logic [plm_pkg::WORD_W-1:0] plane_word;
    logic [plm_pkg::STEP_W-1:0] pwm_step;
    logic [plm_pkg::COL_W-1:0]  column;
    logic [plm_pkg::ROW_W-1:0]  row_group;
    logic                       last;

    modport source (
        output valid, plane_word, pwm_step, column, row_group, last,
        input  ready
    );

    modport sink (
        input  valid, plane_word, pwm_step, column, row_group, last,
        output ready
    );
endinterface

// File: rtl/plm_lane.sv
// One colour lane: the bit is on while the PWM step is below the duty value.
module plm_lane (
    input  logic [plm_pkg::STEP_W-1:0] step,
    input  plm_pkg::duty_t             duty,
    output logic                       bit_on
);

    logic [plm_pkg::DUTY_W-1:0] step_ext;

    // Zero-extend the step to duty width, then compare
    assign step_ext = {{(plm_pkg::DUTY_W - plm_pkg::STEP_W){1'b0}}, step};
    assign bit_on   = (step_ext < duty);

endmodule

// File: rtl/plm_merge.sv
// Merges the lane bits and column control bits into one plane word.
module plm_merge (
    input  plm_pkg::lane_bits_t         lane_bits,
    input  plm_pkg::ctl_t               ctl,
    output logic [plm_pkg::WORD_W-1:0]  plane_word
);

    // Scatter lanes to their word positions, add OE and latch
    always_comb
    begin
        plane_word = '0;
        for (int k = 0; k < plm_pkg::NUM_LANES; k++)
        begin
            plane_word[plm_pkg::LANE_POS[k]] = lane_bits[k];
        end
        plane_word[plm_pkg::OE_POS]  = ctl.oe;
        plane_word[plm_pkg::LAT_POS] = ctl.lat;
    end

endmodule

// File: rtl/led_matrix_pwm_plane_gen_unit.sv
// Top level of the LED matrix PWM bit-plane generator.
//
//  channel  | dir | beat contents                                    | handshake
//  ---------+-----+--------------------------------------------------+------------
//  pixel    | in  | twelve 8-bit duty values (r/g/b x four quadrants) | valid/ready
//  plane    | out | plane_word, pwm_step, column, row_group, last     | valid/ready
//  cfg      | in  | dim_threshold (5 bits)                            | cfg_we only
//
// Each pixel beat yields PWM_STEPS plane beats, one per cycle while plane is not stalled, so
// a new pixel beat is taken only as the last of them issues; the step counter over the twelve compare lanes sets this.
// The next pixel beat is taken in the cycle the last plane beat of the current one
// issues into the output register, so items follow without a gap.
// Reset clears counters, valid flags and sets dim_threshold to 31.
// A stall on plane holds the output register and freezes the step counter.
module led_matrix_pwm_plane_gen_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    plm_in_if.sink                     pixel,
    plm_out_if.source                  plane,
    input  logic                       cfg_we,
    input  logic [plm_pkg::COL_W-1:0]  cfg_wdata
);

    // Control state
    logic                        work_valid_reg, work_valid_next;
    logic [plm_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    logic [plm_pkg::COL_W-1:0]   column_count_reg, column_count_next;
    logic [plm_pkg::ROW_W-1:0]   row_count_reg, row_count_next;
    logic [plm_pkg::COL_W-1:0]   dim_reg;

    // Working item payload
    plm_pkg::duty_t              duty_reg [plm_pkg::NUM_LANES];
    plm_pkg::ctl_t               ctl_reg;
    logic [plm_pkg::COL_W-1:0]   col_item_reg;
    logic [plm_pkg::ROW_W-1:0]   row_item_reg;

    // Output register payload
    logic [plm_pkg::WORD_W-1:0]  word_out_reg;
    logic [plm_pkg::STEP_W-1:0]  step_out_reg;
    logic [plm_pkg::COL_W-1:0]   col_out_reg;
    logic [plm_pkg::ROW_W-1:0]   row_out_reg;
    logic                        last_out_reg;

    logic                        issue;
    logic                        issue_last;
    logic                        accept;
    logic                        last_col;
    plm_pkg::ctl_t               ctl_new;
    plm_pkg::duty_t              duty_in [plm_pkg::NUM_LANES];
    plm_pkg::lane_bits_t         lane_bits;
    logic [plm_pkg::WORD_W-1:0]  word_now;

    // Handshake and issue control
    assign issue      = work_valid_reg && (!out_valid_reg || plane.ready);
    assign issue_last = issue && (step_reg == plm_pkg::STEP_LAST);
    assign pixel.ready = !work_valid_reg || issue_last;
    assign accept     = pixel.valid && pixel.ready;

    // Input lane order matches the plane word layout
    assign duty_in[0]  = pixel.red_p1;
    assign duty_in[1]  = pixel.green_p1;
    assign duty_in[2]  = pixel.blue_p1;
    assign duty_in[3]  = pixel.red_p2;
    assign duty_in[4]  = pixel.green_p2;
    assign duty_in[5]  = pixel.blue_p2;
    assign duty_in[6]  = pixel.red_p3;
    assign duty_in[7]  = pixel.green_p3;
    assign duty_in[8]  = pixel.blue_p3;
    assign duty_in[9]  = pixel.red_p4;
    assign duty_in[10] = pixel.green_p4;
    assign duty_in[11] = pixel.blue_p4;

    // Column control bits, fixed at accept time
    assign last_col    = (column_count_reg == plm_pkg::COL_LAST);
    assign ctl_new.oe  = last_col || (column_count_reg <= dim_reg);
    assign ctl_new.lat = last_col;

    // Next-state logic
    always_comb
    begin
        work_valid_next   = work_valid_reg;
        step_next         = step_reg;
        out_valid_next    = out_valid_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;

        if (issue_last)
        begin
            work_valid_next = 1'b0;
            step_next       = '0;
        end
        else if (issue)
        begin
            step_next = step_reg + 1'b1;
        end
        if (accept)
        begin
            work_valid_next = 1'b1;
        end

        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (plane.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Column and row-group counters advance per item
        if (accept)
        begin
            if (last_col)
            begin
                column_count_next = '0;
                if (row_count_reg == plm_pkg::ROW_LAST)
                begin
                    row_count_next = '0;
                end
                else
                begin
                    row_count_next = row_count_reg + 1'b1;
                end
            end
            else
            begin
                column_count_next = column_count_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg   <= 1'b0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            dim_reg          <= plm_pkg::DIM_RESET;
        end
        else
        begin
            work_valid_reg   <= work_valid_next;
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            if (cfg_we)
            begin
                dim_reg <= cfg_wdata;
            end
        end
    end

    // Working item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < plm_pkg::NUM_LANES; k++)
            begin
                duty_reg[k] <= duty_in[k];
            end
            ctl_reg      <= ctl_new;
            col_item_reg <= column_count_reg;
            row_item_reg <= row_count_reg;
        end
    end

    // Compare lanes, one per colour of each quadrant
    for (genvar g = 0; g < plm_pkg::NUM_LANES; g++)
    begin : g_lane
        plm_lane u_lane (
            .step   (step_reg),
            .duty   (duty_reg[g]),
            .bit_on (lane_bits[g])
        );
    end

    plm_merge u_merge (
        .lane_bits  (lane_bits),
        .ctl        (ctl_reg),
        .plane_word (word_now)
    );

    // Output register
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            word_out_reg <= word_now;
            step_out_reg <= step_reg;
            col_out_reg  <= col_item_reg;
            row_out_reg  <= row_item_reg;
            last_out_reg <= (step_reg == plm_pkg::STEP_LAST);
        end
    end

    assign plane.valid      = out_valid_reg;
    assign plane.plane_word = word_out_reg;
    assign plane.pwm_step   = step_out_reg;
    assign plane.column     = col_out_reg;
    assign plane.row_group  = row_out_reg;
    assign plane.last       = last_out_reg;

    // A new item only enters when the previous one has issued its final step
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!work_valid_reg || issue_last))
        else $error("pixel beat taken while an item is still mid-sequence");

    // Step counter rests at zero between items
    assert property (@(posedge clk) disable iff (!rst_n)
        !work_valid_reg |-> (step_reg == '0))
        else $error("step counter not at zero while idle");

    // Latch is only ever raised together with output enable
    assert property (@(posedge clk) disable iff (!rst_n)
        (plane.valid && plane.plane_word[plm_pkg::LAT_POS])
            |-> plane.plane_word[plm_pkg::OE_POS])
        else $error("latch without output enable");

    // After an issued non-final step the output register holds that step and the item stays in work
    assert property (@(posedge clk) disable iff (!rst_n)
        (issue && !issue_last) |=> (step_out_reg == $past(step_reg) && work_valid_reg))
        else $error("step sequence broken");

endmodule
